@@ design/cpct_pkg.sv @@
// Package: payload types, register indexes and widths for the cylinder contact unit
`timescale 1ns / 1ps
package cpct_pkg;

    localparam int NUM_FACES  = 1024;
    localparam int IDX_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam int SQRT_STAGES = 32;  // one root bit per stage
    localparam int DIV_STAGES  = 33;  // input stage plus one quotient bit per stage

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS    = 3'd0,
        REG_CENTRE_X  = 3'd1,
        REG_CENTRE_Y  = 3'd2,
        REG_STIFFNESS = 3'd3,
        REG_RELAX     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [IDX_W-1:0]   face_index;
        logic signed [31:0] rest_x;
        logic signed [31:0] rest_y;
        logic signed [31:0] disp_x;
        logic signed [31:0] disp_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] traction_x;
        logic signed [31:0] traction_y;
        logic               in_contact;
    } out_item_t;

endpackage

@@ design/cpct_div.sv @@
// Module: pipelined restoring divider, one quotient bit per stage, with cap
`timescale 1ns / 1ps
module cpct_div (
    input  logic        aclk,
    input  logic        en,
    input  logic [95:0] num,
    input  logic [47:0] den,
    input  logic        neg_in,
    output logic [31:0] q_abs,
    output logic        neg_out
);
    // Quotient is capped at 2^31 (neg) or 2^31-1 (pos). The top 64 bits of
    // num divided by den are checked up front: any quotient >= 2^32 means cap.
    // 32 stages of one bit each follow.
    localparam int STG = cpct_pkg::DIV_STAGES;

    logic [95:0] num_reg [STG];
    logic [48:0] rem_reg [STG];
    logic [32:0] q_reg   [STG];
    logic        ovf_reg [STG];
    logic        neg_reg [STG];
    logic [47:0] den_reg [STG];

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= num;
            den_reg[0] <= den;
            neg_reg[0] <= neg_in;
            // quotient >= 2^32 iff num[95:32] >= den
            ovf_reg[0] <= (num[95:32] >= {16'd0, den});
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
        end
    end

    // Stage 0 precharges remainder with num[95:32] mod den is not needed:
    // when not overflowing, num[95:32] < den, so start remainder from it.
    genvar g;
    generate
        for (g = 1; g < STG; g++) begin : g_stage
            logic [48:0] r_in;
            logic [48:0] r_sh;
            always_comb begin
                r_in = (g == 1) ? {1'b0, num_reg[0][79:32]} : rem_reg[g-1];
                r_sh = {r_in[47:0], num_reg[g-1][32-g]};
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    num_reg[g] <= num_reg[g-1];
                    den_reg[g] <= den_reg[g-1];
                    neg_reg[g] <= neg_reg[g-1];
                    ovf_reg[g] <= ovf_reg[g-1];
                    if (r_sh >= {1'b0, den_reg[g-1]}) begin
                        rem_reg[g] <= r_sh - {1'b0, den_reg[g-1]};
                        q_reg[g]   <= {q_reg[g-1][31:0], 1'b1};
                    end else begin
                        rem_reg[g] <= r_sh;
                        q_reg[g]   <= {q_reg[g-1][31:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        neg_out = neg_reg[STG-1];
        if (ovf_reg[STG-1] || q_reg[STG-1][31:0] > (neg_out ? 32'h8000_0000 : 32'h7FFF_FFFF))
            q_abs = neg_out ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            q_abs = q_reg[STG-1][31:0];
    end
endmodule

@@ design/cylinder_penalty_contact_traction_unit.sv @@
// Top level: cylinder penalty contact traction with relaxed per-face store
`timescale 1ns / 1ps
// One face can enter per cycle while the pipe advances, and one result
// leaves per face, in order. The path is a pipeline of 74 register stages:
// offset and squares, a 32-step square root (one result bit per stage), the
// stiffness times overlap product, a split force times offset product and
// its sum, a 96 by 48 divide per component (one quotient bit per stage), a
// read of the traction memory, a blend and a write back. The whole pipe
// advances only when the result register is free or being taken, so ready
// is high whenever the output stage can move and no clearing pass runs. The
// traction memory (1024 x 64) is read in the stage ahead of the blend;
// results still in flight to the same face are forwarded. After reset a
// clearing pass writes zero to every entry, one per cycle, and no face is
// accepted until it has finished.
module cylinder_penalty_contact_traction_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cpct_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cpct_pkg::out_item_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    localparam int SQ  = cpct_pkg::SQRT_STAGES;  // root stages
    localparam int DV  = cpct_pkg::DIV_STAGES;   // divider stages

    // configuration registers
    logic [30:0]        radius_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic [31:0]        stiff_reg;
    logic [16:0]        relax_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0; cx_reg <= '0; cy_reg <= '0;
            stiff_reg <= '0; relax_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                cpct_pkg::REG_RADIUS:    radius_reg <= cfg_data[30:0];
                cpct_pkg::REG_CENTRE_X:  cx_reg     <= cfg_data;
                cpct_pkg::REG_CENTRE_Y:  cy_reg     <= cfg_data;
                cpct_pkg::REG_STIFFNESS: stiff_reg  <= cfg_data;
                cpct_pkg::REG_RELAX:     relax_reg  <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // clearing pass
    logic        clr_reg;
    logic [10:0] clr_cnt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= 1'b1; clr_cnt_reg <= '0;
        end else if (clr_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 11'd1;
            if (clr_cnt_reg == 11'(cpct_pkg::NUM_FACES - 1)) clr_reg <= 1'b0;
        end
    end

    // advance whole pipe when output stage free
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv && !clr_reg;
    logic acc;
    assign acc = s_valid && s_ready;

    // stage 1: offsets
    logic               v1_reg;
    logic [9:0]         i1_reg;
    logic signed [33:0] dx1_reg, dy1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= acc;
        if (adv) begin
            i1_reg  <= s_data.face_index;
            dx1_reg <= 34'(s_data.rest_x) + 34'(s_data.disp_x) - 34'(cx_reg);
            dy1_reg <= 34'(s_data.rest_y) + 34'(s_data.disp_y) - 34'(cy_reg);
        end
    end

    // stage 2: absolute values
    logic        v2_reg;
    logic [9:0]  i2_reg;
    logic [33:0] ax2_reg, ay2_reg;
    logic        sx2_reg, sy2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            i2_reg  <= i1_reg;
            sx2_reg <= dx1_reg[33];
            sy2_reg <= dy1_reg[33];
            ax2_reg <= dx1_reg[33] ? 34'(-dx1_reg) : 34'(dx1_reg);
            ay2_reg <= dy1_reg[33] ? 34'(-dy1_reg) : 34'(dy1_reg);
        end
    end

    // stage 3: squares (only meaningful when both below radius < 2^31)
    logic        v3_reg, inb3_reg;
    logic [9:0]  i3_reg;
    logic [30:0] ax3_reg, ay3_reg;
    logic        sx3_reg, sy3_reg;
    logic [61:0] sqx3_reg, sqy3_reg, rr3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
        if (adv) begin
            i3_reg   <= i2_reg;
            sx3_reg  <= sx2_reg; sy3_reg <= sy2_reg;
            inb3_reg <= (ax2_reg < 34'(radius_reg)) && (ay2_reg < 34'(radius_reg));
            ax3_reg  <= ax2_reg[30:0];
            ay3_reg  <= ay2_reg[30:0];
            sqx3_reg <= ax2_reg[30:0] * ax2_reg[30:0];
            sqy3_reg <= ay2_reg[30:0] * ay2_reg[30:0];
            rr3_reg  <= radius_reg * radius_reg;
        end
    end

    // stage 4: sum and inside test
    logic        v4_reg, in4_reg;
    logic [9:0]  i4_reg;
    logic [30:0] ax4_reg, ay4_reg;
    logic        sx4_reg, sy4_reg;
    logic [62:0] s4_reg;
    logic [62:0] s_sum;
    assign s_sum = 63'(sqx3_reg) + 63'(sqy3_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
        if (adv) begin
            i4_reg  <= i3_reg;
            sx4_reg <= sx3_reg; sy4_reg <= sy3_reg;
            ax4_reg <= ax3_reg; ay4_reg <= ay3_reg;
            in4_reg <= inb3_reg && (s_sum < 63'(rr3_reg));
            s4_reg  <= s_sum;
        end
    end

    // square root pipeline: 32 stages, one result bit each
    logic [63:0] sq_rem_reg [SQ+1];
    logic [31:0] sq_res_reg [SQ+1];
    logic        sq_v_reg   [SQ+1];
    logic        sq_in_reg  [SQ+1];
    logic [9:0]  sq_i_reg   [SQ+1];
    logic [30:0] sq_ax_reg  [SQ+1];
    logic [30:0] sq_ay_reg  [SQ+1];
    logic        sq_sx_reg  [SQ+1];
    logic        sq_sy_reg  [SQ+1];

    always_comb begin
        sq_rem_reg[0] = {1'b0, s4_reg};
        sq_res_reg[0] = '0;
        sq_v_reg[0]   = v4_reg;
        sq_in_reg[0]  = in4_reg;
        sq_i_reg[0]   = i4_reg;
        sq_ax_reg[0]  = ax4_reg; sq_ay_reg[0] = ay4_reg;
        sq_sx_reg[0]  = sx4_reg; sq_sy_reg[0] = sy4_reg;
    end

    genvar k;
    generate
        for (k = 1; k <= SQ; k++) begin : g_sqrt
            logic [63:0] trial;
            logic [63:0] bitv;
            // trial is (4*root + 1) scaled to this bit position
            always_comb begin
                bitv  = 64'd1 << (2 * (SQ - k));
                trial = ({32'd0, sq_res_reg[k-1]} << (2 * (SQ - k) + 2)) | bitv;
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) sq_v_reg[k] <= 1'b0;
                else if (adv) sq_v_reg[k] <= sq_v_reg[k-1];
                if (adv) begin
                    sq_in_reg[k] <= sq_in_reg[k-1];
                    sq_i_reg[k]  <= sq_i_reg[k-1];
                    sq_ax_reg[k] <= sq_ax_reg[k-1]; sq_ay_reg[k] <= sq_ay_reg[k-1];
                    sq_sx_reg[k] <= sq_sx_reg[k-1]; sq_sy_reg[k] <= sq_sy_reg[k-1];
                    if (sq_rem_reg[k-1] >= trial) begin
                        sq_rem_reg[k] <= sq_rem_reg[k-1] - trial;
                        sq_res_reg[k] <= {sq_res_reg[k-1][30:0], 1'b1};
                    end else begin
                        sq_rem_reg[k] <= sq_rem_reg[k-1];
                        sq_res_reg[k] <= {sq_res_reg[k-1][30:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // force = stiffness * (radius - mag); mag < radius when inside
    logic        vf_reg, inf_reg, zf_reg;
    logic [9:0]  if_reg;
    logic [30:0] axf_reg, ayf_reg, magf_reg;
    logic        sxf_reg, syf_reg;
    logic [62:0] force_reg;
    logic [30:0] mag_w;
    assign mag_w = sq_res_reg[SQ][30:0];
    always_ff @(posedge aclk) begin
        if (!aresetn) vf_reg <= 1'b0;
        else if (adv) vf_reg <= sq_v_reg[SQ];
        if (adv) begin
            if_reg    <= sq_i_reg[SQ];
            inf_reg   <= sq_in_reg[SQ];
            zf_reg    <= !sq_in_reg[SQ] || (mag_w == '0);
            axf_reg   <= sq_ax_reg[SQ]; ayf_reg <= sq_ay_reg[SQ];
            sxf_reg   <= sq_sx_reg[SQ]; syf_reg <= sq_sy_reg[SQ];
            magf_reg  <= mag_w;
            force_reg <= stiff_reg * (radius_reg - mag_w);
        end
    end

    // partial products of force*|d|: low 32 and high 31 bits of force
    logic        vn_reg, inn_reg, zn_reg;
    logic [9:0]  in_reg;
    logic        sxn_reg, syn_reg;
    logic [62:0] pxl_reg, pyl_reg;
    logic [61:0] pxh_reg, pyh_reg;
    logic [47:0] den_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vn_reg <= 1'b0;
        else if (adv) vn_reg <= vf_reg;
        if (adv) begin
            in_reg  <= if_reg;
            inn_reg <= inf_reg;
            zn_reg  <= zf_reg;
            sxn_reg <= sxf_reg; syn_reg <= syf_reg;
            pxl_reg <= force_reg[31:0] * axf_reg;
            pyl_reg <= force_reg[31:0] * ayf_reg;
            pxh_reg <= force_reg[62:32] * axf_reg;
            pyh_reg <= force_reg[62:32] * ayf_reg;
            den_reg <= {1'b0, magf_reg, 16'd0} | {47'd0, zf_reg}; // avoid zero
        end
    end

    // numerators force*|d| (94 bits), denominator mag*65536
    logic        vp_reg, inp_reg, zp_reg;
    logic [9:0]  ip_reg;
    logic        sxp_reg, syp_reg;
    logic [95:0] nx_reg, ny_reg;
    logic [47:0] denp_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vp_reg <= 1'b0;
        else if (adv) vp_reg <= vn_reg;
        if (adv) begin
            ip_reg   <= in_reg;
            inp_reg  <= inn_reg;
            zp_reg   <= zn_reg;
            sxp_reg  <= sxn_reg; syp_reg <= syn_reg;
            nx_reg   <= 96'({pxh_reg, 32'd0}) + 96'(pxl_reg);
            ny_reg   <= 96'({pyh_reg, 32'd0}) + 96'(pyl_reg);
            denp_reg <= den_reg;
        end
    end

    logic [31:0] qx, qy;
    logic        nx_neg, ny_neg;
    cpct_div u_divx (.aclk(aclk), .en(adv), .num(nx_reg), .den(denp_reg),
                     .neg_in(sxp_reg), .q_abs(qx), .neg_out(nx_neg));
    cpct_div u_divy (.aclk(aclk), .en(adv), .num(ny_reg), .den(denp_reg),
                     .neg_in(syp_reg), .q_abs(qy), .neg_out(ny_neg));

    // sideband delay alongside the dividers
    logic       dv_v_reg  [DV];
    logic       dv_in_reg [DV];
    logic       dv_z_reg  [DV];
    logic [9:0] dv_i_reg  [DV];
    always_ff @(posedge aclk) begin
        for (int j = 0; j < DV; j++) begin
            if (!aresetn) dv_v_reg[j] <= 1'b0;
            else if (adv) dv_v_reg[j] <= (j == 0) ? vp_reg : dv_v_reg[j-1];
            if (adv) begin
                dv_in_reg[j] <= (j == 0) ? inp_reg : dv_in_reg[j-1];
                dv_z_reg[j]  <= (j == 0) ? zp_reg  : dv_z_reg[j-1];
                dv_i_reg[j]  <= (j == 0) ? ip_reg  : dv_i_reg[j-1];
            end
        end
    end

    // raw traction, memory read issued here
    logic               vr_reg, inr_reg;
    logic [9:0]         ir_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic [63:0]        mem [cpct_pkg::NUM_FACES];
    logic [63:0]        rd_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vr_reg <= 1'b0;
        else if (adv) vr_reg <= dv_v_reg[DV-1];
        if (adv) begin
            ir_reg  <= dv_i_reg[DV-1];
            inr_reg <= dv_in_reg[DV-1];
            rx_reg  <= dv_z_reg[DV-1] ? 32'sd0 : (nx_neg ? -qx : qx);
            ry_reg  <= dv_z_reg[DV-1] ? 32'sd0 : (ny_neg ? -qy : qy);
            rd_reg  <= mem[dv_i_reg[DV-1]];
        end
    end

    // blend stage: forward the result written last cycle
    // (read issued before it landed)
    logic               wv_reg;
    logic [9:0]         wi_reg;
    logic [63:0]        wd_reg;
    logic [63:0]        prev;
    logic [16:0]        r_eff;
    logic signed [49:0] sumx, sumy;
    logic signed [31:0] tx, ty;
    always_comb begin
        prev  = (wv_reg && wi_reg == ir_reg) ? wd_reg : rd_reg;
        r_eff = (relax_reg > cpct_pkg::ONE_Q16) ? cpct_pkg::ONE_Q16 : relax_reg;
        sumx  = 50'(rx_reg) * $signed({1'b0, r_eff})
              + 50'($signed(prev[31:0])) * $signed({1'b0, 17'(cpct_pkg::ONE_Q16 - r_eff)})
              + 50'sd32768;
        sumy  = 50'(ry_reg) * $signed({1'b0, r_eff})
              + 50'($signed(prev[63:32])) * $signed({1'b0, 17'(cpct_pkg::ONE_Q16 - r_eff)})
              + 50'sd32768;
        tx = sumx[47:16];
        ty = sumy[47:16];
    end

    // write back and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wv_reg  <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            if (adv) begin
                wv_reg  <= vr_reg;
                m_valid <= vr_reg;
            end
        end
        if (adv) begin
            wi_reg <= ir_reg;
            wd_reg <= {ty, tx};
            m_data.traction_x <= tx;
            m_data.traction_y <= ty;
            m_data.in_contact <= inr_reg;
        end
        if (clr_reg)
            mem[clr_cnt_reg[9:0]] <= '0;
        else if (adv && vr_reg)
            mem[ir_reg] <= {ty, tx};
    end

endmodule

@@ tb/cpct_checker.sv @@
// Checker: watches the face, result and register channels, predicts and compares results
`timescale 1ns / 1ps
module cpct_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  cpct_pkg::in_item_t   s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  cpct_pkg::out_item_t  m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   errors,
    output int                   pending
);
    import cpct_pkg::*;

    logic [63:0]  face_traction [NUM_FACES];
    logic [30:0]  radius_q;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic [31:0]  stiffness_q;
    logic [16:0]  relax_q;
    out_item_t    traction_queue[$];

    initial errors = 0;
    assign pending = traction_queue.size();

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // truncated magnitude of force * |d| / (mag * 65536), then sign, saturated
    function automatic longint radial_share(logic [63:0] force_q, longint d, logic [63:0] mag);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] cap;
        logic [63:0]  ad;
        ad  = (d < 0) ? 64'(-d) : 64'(d);
        num = {64'd0, force_q} * {64'd0, ad};
        q   = num / ({64'd0, mag} << 16);
        cap = (d < 0) ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > cap) q = cap;
        return (d < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint relax_blend(longint raw, longint prev, longint r);
        longint sum;
        sum = r * raw + (65536 - r) * prev + 32768;
        return sum >>> 16;
    endfunction

    function automatic out_item_t contact_traction(in_item_t f);
        out_item_t   o;
        longint      dx, dy, rawx, rawy, tx, ty, r;
        logic [63:0] adx, ady, rad, s, mag, force_q, prev;
        dx  = longint'(f.rest_x) + longint'(f.disp_x) - longint'(axis_x);
        dy  = longint'(f.rest_y) + longint'(f.disp_y) - longint'(axis_y);
        adx = (dx < 0) ? 64'(-dx) : 64'(dx);
        ady = (dy < 0) ? 64'(-dy) : 64'(dy);
        rad = {33'd0, radius_q};
        r   = (relax_q > ONE_Q16) ? 65536 : longint'(relax_q);
        rawx = 0;
        rawy = 0;
        o.in_contact = 1'b0;
        if (adx < rad && ady < rad) begin
            s = adx * adx + ady * ady;
            if (s < rad * rad) begin
                o.in_contact = 1'b1;
                mag = floor_sqrt(s);
                if (mag != 0) begin
                    force_q = {32'd0, stiffness_q} * (rad - mag);
                    rawx = radial_share(force_q, dx, mag);
                    rawy = radial_share(force_q, dy, mag);
                end
            end
        end
        prev = face_traction[f.face_index];
        tx = relax_blend(rawx, longint'($signed(prev[31:0])), r);
        ty = relax_blend(rawy, longint'($signed(prev[63:32])), r);
        o.traction_x = tx[31:0];
        o.traction_y = ty[31:0];
        face_traction[f.face_index] = {ty[31:0], tx[31:0]};
        return o;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            foreach (face_traction[i]) face_traction[i] = '0;
            radius_q    = '0;
            axis_x      = '0;
            axis_y      = '0;
            stiffness_q = '0;
            relax_q     = '0;
            traction_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_RADIUS:    radius_q    = cfg_data[30:0];
                    REG_CENTRE_X:  axis_x      = cfg_data;
                    REG_CENTRE_Y:  axis_y      = cfg_data;
                    REG_STIFFNESS: stiffness_q = cfg_data;
                    REG_RELAX:     relax_q     = cfg_data[16:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                traction_queue.push_back(contact_traction(s_data));
            if (m_valid && m_ready) begin
                if (traction_queue.size() == 0) begin
                    $error("unexpected result transfer: traction_x %0d", m_data.traction_x);
                    errors++;
                end else begin
                    want = traction_queue.pop_front();
                    if (m_data.traction_x !== want.traction_x) begin
                        $error("traction_x: expected %0d, got %0d",
                               want.traction_x, m_data.traction_x);
                        errors++;
                    end
                    if (m_data.traction_y !== want.traction_y) begin
                        $error("traction_y: expected %0d, got %0d",
                               want.traction_y, m_data.traction_y);
                        errors++;
                    end
                    if (m_data.in_contact !== want.in_contact) begin
                        $error("in_contact: expected %0d, got %0d",
                               want.in_contact, m_data.in_contact);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

@@ tb/tb_cylinder_penalty_contact_traction_unit.sv @@
// Testbench top: drives faces and register writes, paces the result side, gives the verdict
`timescale 1ns / 1ps
module tb_cylinder_penalty_contact_traction_unit;
    import cpct_pkg::*;

    localparam int PHASES         = 8;
    localparam int FACES_PER_PHASE = 237;
    localparam int DRAIN_CYCLES   = 120;  // longer than the pipeline depth
    localparam int HOLD_CYCLES    = 400;  // long receiver hold-off

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int errors;
    int pending;

    // pacing knobs, percent of cycles spent idle or stalled
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;

    // shadow of the current register values, used to aim faces at the cylinder
    longint cur_radius;
    longint cur_cx;
    longint cur_cy;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    cylinder_penalty_contact_traction_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cpct_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // Result side: random stalls, plus one long hold-off when requested so the
    // pipe fills up and pushes back on the face channel.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // hard stop in case the handshakes lock up
    initial begin
        #1000000;
        $display("tb_cylinder_penalty_contact_traction_unit NOT OK");
        $finish;
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RADIUS:   cur_radius = longint'(value[30:0]);
            REG_CENTRE_X: cur_cx = longint'($signed(value));
            REG_CENTRE_Y: cur_cy = longint'($signed(value));
            default: ;
        endcase
    endtask

    // Offer one face and hold it until the transfer; then idle each following
    // cycle with the set odds.
    task automatic send_face(in_item_t f);
        s_valid <= 1'b1;
        s_data  <= f;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
    endtask

    function automatic in_item_t face_at(logic [9:0] idx, longint px, longint py);
        in_item_t f;
        longint rx, ry;
        rx = (px >>> 1) + longint'($urandom_range(2000)) - 1000;
        ry = (py >>> 1) + longint'($urandom_range(2000)) - 1000;
        f.face_index = idx;
        f.rest_x = rx[31:0];
        f.rest_y = ry[31:0];
        f.disp_x = 32'(px - rx);
        f.disp_y = 32'(py - ry);
        return f;
    endfunction

    function automatic bit fits32(longint v);
        return v >= -64'sd2147483648 && v <= 64'sd2147483647;
    endfunction

    // Mostly faces aimed around the cylinder rim; the rest raw noise.
    function automatic in_item_t random_face();
        in_item_t f;
        longint span, px, py;
        logic [9:0] idx;
        // a handful of hot faces keeps several updates to one face in flight
        idx = ($urandom_range(1)) ? 10'($urandom_range(7)) : 10'($urandom);
        span = cur_radius + cur_radius / 4 + 1;
        px = cur_cx + longint'($urandom_range(0, 32'(2 * span))) - span;
        py = cur_cy + longint'($urandom_range(0, 32'(2 * span))) - span;
        if ($urandom_range(99) < 70 && span < 64'sd1073741824
            && fits32(px >>> 1) && fits32(py >>> 1)) begin
            f = face_at(idx, px, py);
            if (fits32(longint'(f.rest_x) + longint'(f.disp_x) - px) || 1)
                return f;
        end
        f.face_index = idx;
        f.rest_x = $urandom;
        f.rest_y = $urandom;
        f.disp_x = $urandom;
        f.disp_y = $urandom;
        return f;
    endfunction

    // Register settings per phase, extremes included.
    task automatic program_phase(int p);
        logic [31:0] rad, cx, cy, stiff, relax;
        rad   = $urandom_range(32'h0000_1000, 32'h00FF_FFFF);
        cx    = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        cy    = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        stiff = $urandom;
        relax = $urandom_range(0, 65536);
        case (p)
            1: begin rad = $urandom_range(32'h40, 32'h4000); relax = 32'd65536; end
            2: rad = 32'd0;                                     // nothing can touch
            3: begin relax = 32'd0; stiff = 32'hFFFF_FFFF; end  // store never moves
            4: begin rad = 32'h3FFF_FFFF; cx = 32'd0; cy = 32'd0; end
            5: begin
                rad = 32'h7FFF_FFFF; stiff = 32'hFFFF_FFFF;
                cx = 32'h8000_0000; cy = 32'h7FFF_FFFF;
            end
            6: relax = 32'h0001_FFFF;                           // above one, clipped
            7: begin cx = $urandom; cy = $urandom; rad = $urandom; end
            default: ;
        endcase
        write_reg(REG_RADIUS, rad);
        write_reg(REG_CENTRE_X, cx);
        write_reg(REG_CENTRE_Y, cy);
        write_reg(REG_STIFFNESS, stiff);
        write_reg(REG_RELAX, relax);
    endtask

    // wait for the pipe to empty before touching registers
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        longint one;
        in_item_t f;
        one = 65536;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: radius 10, axis at origin, unit stiffness, full relaxation
        write_reg(REG_RADIUS, 32'(10 * one));
        write_reg(REG_CENTRE_X, 32'd0);
        write_reg(REG_CENTRE_Y, 32'd0);
        write_reg(REG_STIFFNESS, 32'(one));
        write_reg(REG_RELAX, 32'd65536);
        send_face(face_at(10'd0, 0, 0));                      // on the axis
        send_face(face_at(10'd1, 3 * one, 0));                // inside on +x
        send_face(face_at(10'd2, 0, -4 * one));               // inside on -y
        send_face(face_at(10'd3, -3 * one, 4 * one));         // 3-4-5 inside
        send_face(face_at(10'd4, 10 * one, 0));               // on the rim, outside
        send_face(face_at(10'd5, 10 * one - 1, 0));           // just inside
        send_face(face_at(10'd6, 8 * one, 8 * one));          // outside corner
        send_face(face_at(10'd1023, 1, -1));                  // top index, tiny offset
        send_face(face_at(10'd1023, -7 * one, -7 * one));     // repeat face
        f = '{face_index: 10'h3FF, rest_x: 32'h7FFF_FFFF, rest_y: 32'h7FFF_FFFF,
              disp_x: 32'h7FFF_FFFF, disp_y: 32'h7FFF_FFFF};
        send_face(f);                                         // largest positive sum
        f = '{face_index: 10'd0, rest_x: 32'h8000_0000, rest_y: 32'h8000_0000,
              disp_x: 32'h8000_0000, disp_y: 32'h8000_0000};
        send_face(f);                                         // largest negative sum
        f = '{face_index: 10'd7, rest_x: 32'h7FFF_FFFF, rest_y: 32'h8000_0000,
              disp_x: 32'h8000_0001, disp_y: 32'h7FFF_FFFF};
        send_face(f);                                         // cancels to just off the axis
        drain();
        write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);              // saturate raw traction
        write_reg(REG_RELAX, 32'd32768);
        send_face(face_at(10'd1, 1 * one, 0));
        send_face(face_at(10'd2, 0, -1));
        send_face(face_at(10'd1, -one / 2, one / 3));
        send_face(face_at(10'd8, 9 * one, 0));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            program_phase(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (int i = 0; i < FACES_PER_PHASE; i++) begin
                if (p == 0 && i == 60) hold_request = 1'b1;
                send_face(random_face());
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_cylinder_penalty_contact_traction_unit OK");
        end else begin
            $display("tb_cylinder_penalty_contact_traction_unit NOT OK");
        end
        $finish;
    end
endmodule
